/* hw/rtl/nssd_pkg.sv */
// Package for the normalized SSD patch score block.
// Holds the sizing constants shared by the datapath; no dependencies.
`timescale 1ns / 1ps

package nssd_pkg;

  localparam int MaxPixels = 1024;
  localparam int PixW      = 8;
  localparam int CntW      = $clog2(MaxPixels + 1);
  localparam int SumW      = PixW + $clog2(MaxPixels);
  localparam int SqW       = 2 * PixW + $clog2(MaxPixels);
  localparam int VarW      = CntW + SqW;
  localparam int CvW       = VarW + 1;

  localparam int ScoreW    = 19;
  localparam int SdW       = 15;
  localparam int SdFrac    = 16;

  localparam int SearchTop = 17;
  localparam int MW        = SearchTop + 1;
  localparam int KW        = $clog2(MW);
  localparam int MsqW      = 2 * MW;
  localparam int PvW       = 2 * VarW;
  localparam int XxW       = 2 * CvW;
  localparam int XShift    = 2 * SearchTop;
  localparam int ProdW     = PvW + MsqW;
  localparam int MbW       = CvW;

  localparam int SqIter    = (VarW + SdFrac + 1) / 2;
  localparam int SqInW     = 2 * SqIter;
  localparam int RemW      = SqIter + 2;
  localparam int IterW     = $clog2(SqIter);
  localparam int DremW     = CntW + 1;

  localparam logic [ScoreW-1:0] HalfRange = ScoreW'(1) << SearchTop;
  localparam logic [ScoreW-1:0] ScoreOne  = ScoreW'(1) << 16;

endpackage

/* hw/rtl/normalized_ssd_patch_score.sv */
// Normalized SSD patch score: accumulator, sequencer and shared datapath.
// Depends on nssd_pkg for all sizing constants.
`timescale 1ns / 1ps

// Pixel pairs are taken one per cycle while busy is low; each of the first 1024 pairs of a
// patch is accumulated. The pair flagged last starts the finishing sequence, during which
// busy stays high: a shift-add multiplier (one multiplier bit per cycle) forms the variances,
// covariance and the products of an 18-step search for the score, and a two-bit-per-cycle
// square root plus a one-bit-per-cycle divider form each deviation. The sequence's length is
// set mostly by the multiplier passes of the score search. The result then appears for
// exactly one cycle with valid_o high and must be captured then.
module normalized_ssd_patch_score
  import nssd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [PixW-1:0]   pix_a_i,
  input  logic [PixW-1:0]   pix_b_i,
  input  logic              last_i,
  output logic              valid_o,
  output logic [ScoreW-1:0] score_o,
  output logic [SdW-1:0]    sd_a_o,
  output logic [SdW-1:0]    sd_b_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_MUL, ST_SQRT, ST_DIV, ST_SCORE, ST_OUT
  } state_e;

  typedef enum logic [3:0] {
    OP_NAA, OP_AA, OP_NBB, OP_BB, OP_NAB, OP_AB,
    OP_SDA, OP_SDB, OP_XX, OP_PP, OP_MSQ, OP_MP
  } op_e;

  state_e state_q;
  op_e    op_q;

  logic [CntW-1:0]   cnt_q;
  logic [SumW-1:0]   sa_q, sb_q;
  logic [SqW-1:0]    saa_q, sbb_q, sab_q;

  logic [VarW-1:0]   va_q, vb_q;
  logic [CvW-1:0]    cv_q;
  logic [XxW-1:0]    xx_q;
  logic [PvW-1:0]    pv_q;
  logic [MsqW-1:0]   msq_q;
  logic [MW-1:0]     m_q;
  logic              eq_q;
  logic [KW-1:0]     k_q;

  logic [ProdW-1:0]  ma_q, mp_q;
  logic [MbW-1:0]    mb_q;

  logic [SqInW-1:0]  sx_q;
  logic [RemW-1:0]   rem_q;
  logic [SqIter-1:0] root_q;
  logic [DremW-1:0]  drem_q;
  logic [IterW-1:0]  iter_q;

  logic              valid_q;
  logic [ScoreW-1:0] score_q;
  logic [SdW-1:0]    sda_q, sdb_q;

  logic              accept;
  logic              room;
  logic [MW-1:0]     trial;
  logic [CvW-1:0]    cv_abs;
  logic [ProdW-1:0]  xs;
  logic [ProdW-1:0]  mp_next;
  logic [RemW-1:0]   rem2;
  logic [RemW-1:0]   sq_trial;
  logic [DremW-1:0]  drem2;
  logic              cv_pos;
  logic [ScoreW-1:0] score_calc;

  assign accept   = start && !busy;
  assign room     = cnt_q < CntW'(MaxPixels);
  assign trial    = m_q | (MW'(1) << k_q);
  assign cv_abs   = cv_q[CvW-1] ? (~cv_q + CvW'(1)) : cv_q;
  assign xs       = ProdW'({xx_q, {XShift{1'b0}}});
  assign mp_next  = mb_q[0] ? (mp_q + ma_q) : mp_q;
  assign rem2     = {rem_q[RemW-3:0], sx_q[SqInW-1 -: 2]};
  assign sq_trial = {root_q, 2'b01};
  assign drem2    = {drem_q[DremW-2:0], root_q[SqIter-1]};
  assign cv_pos   = !cv_q[CvW-1] && (cv_q != '0);
  assign score_calc = cv_pos ? (HalfRange - (ScoreW'(m_q) + ScoreW'(!eq_q)))
                             : (HalfRange + ScoreW'(m_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_NAA;
      cnt_q   <= '0;
      sa_q    <= '0;
      sb_q    <= '0;
      saa_q   <= '0;
      sbb_q   <= '0;
      sab_q   <= '0;
      va_q    <= '0;
      vb_q    <= '0;
      cv_q    <= '0;
      xx_q    <= '0;
      pv_q    <= '0;
      msq_q   <= '0;
      m_q     <= '0;
      eq_q    <= 1'b0;
      k_q     <= '0;
      ma_q    <= '0;
      mb_q    <= '0;
      mp_q    <= '0;
      sx_q    <= '0;
      rem_q   <= '0;
      root_q  <= '0;
      drem_q  <= '0;
      iter_q  <= '0;
      valid_q <= 1'b0;
      score_q <= '0;
      sda_q   <= '0;
      sdb_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (room) begin
              cnt_q <= cnt_q + CntW'(1);
              sa_q  <= sa_q + SumW'(pix_a_i);
              sb_q  <= sb_q + SumW'(pix_b_i);
              saa_q <= saa_q + SqW'(pix_a_i * pix_a_i);
              sbb_q <= sbb_q + SqW'(pix_b_i * pix_b_i);
              sab_q <= sab_q + SqW'(pix_a_i * pix_b_i);
            end
            if (last_i) begin
              op_q    <= OP_NAA;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          mp_q    <= '0;
          state_q <= ST_MUL;
          unique case (op_q)
            OP_NAA: begin ma_q <= ProdW'(saa_q);  mb_q <= MbW'(cnt_q); end
            OP_AA:  begin ma_q <= ProdW'(sa_q);   mb_q <= MbW'(sa_q);  end
            OP_NBB: begin ma_q <= ProdW'(sbb_q);  mb_q <= MbW'(cnt_q); end
            OP_BB:  begin ma_q <= ProdW'(sb_q);   mb_q <= MbW'(sb_q);  end
            OP_NAB: begin ma_q <= ProdW'(sab_q);  mb_q <= MbW'(cnt_q); end
            OP_AB:  begin ma_q <= ProdW'(sa_q);   mb_q <= MbW'(sb_q);  end
            OP_SDA, OP_SDB: begin
              sx_q    <= SqInW'({(op_q == OP_SDA) ? va_q : vb_q, {SdFrac{1'b0}}});
              rem_q   <= '0;
              root_q  <= '0;
              iter_q  <= '0;
              state_q <= ST_SQRT;
            end
            OP_XX: begin
              if (va_q == '0 || vb_q == '0) begin
                score_q <= (va_q == '0 && vb_q == '0) ? '0 : ScoreOne;
                state_q <= ST_OUT;
              end else begin
                ma_q <= ProdW'(cv_abs);
                mb_q <= MbW'(cv_abs);
              end
            end
            OP_PP:  begin ma_q <= ProdW'(va_q);   mb_q <= MbW'(vb_q);  end
            OP_MSQ: begin ma_q <= ProdW'(trial);  mb_q <= MbW'(trial); end
            OP_MP:  begin ma_q <= ProdW'(pv_q);   mb_q <= MbW'(msq_q); end
            default: state_q <= ST_IDLE;
          endcase
        end
        ST_MUL: begin
          if (mb_q != '0) begin
            mp_q <= mp_next;
            ma_q <= ma_q << 1;
            mb_q <= mb_q >> 1;
          end else begin
            state_q <= ST_LOAD;
            unique case (op_q)
              OP_NAA: begin va_q <= mp_q[VarW-1:0];        op_q <= OP_AA;  end
              OP_AA:  begin va_q <= va_q - mp_q[VarW-1:0]; op_q <= OP_NBB; end
              OP_NBB: begin vb_q <= mp_q[VarW-1:0];        op_q <= OP_BB;  end
              OP_BB:  begin vb_q <= vb_q - mp_q[VarW-1:0]; op_q <= OP_NAB; end
              OP_NAB: begin cv_q <= mp_q[CvW-1:0];         op_q <= OP_AB;  end
              OP_AB:  begin cv_q <= cv_q - mp_q[CvW-1:0];  op_q <= OP_SDA; end
              OP_XX:  begin xx_q <= mp_q[XxW-1:0];         op_q <= OP_PP;  end
              OP_PP: begin
                pv_q <= mp_q[PvW-1:0];
                m_q  <= '0;
                eq_q <= 1'b0;
                k_q  <= KW'(SearchTop);
                op_q <= OP_MSQ;
              end
              OP_MSQ: begin msq_q <= mp_q[MsqW-1:0]; op_q <= OP_MP; end
              OP_MP: begin
                if (mp_q <= xs) begin
                  m_q  <= trial;
                  eq_q <= (mp_q == xs);
                end
                if (k_q == '0) begin
                  state_q <= ST_SCORE;
                end else begin
                  k_q  <= k_q - KW'(1);
                  op_q <= OP_MSQ;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_SQRT: begin
          sx_q <= sx_q << 2;
          if (rem2 >= sq_trial) begin
            rem_q  <= rem2 - sq_trial;
            root_q <= {root_q[SqIter-2:0], 1'b1};
          end else begin
            rem_q  <= rem2;
            root_q <= {root_q[SqIter-2:0], 1'b0};
          end
          if (iter_q == IterW'(SqIter - 1)) begin
            iter_q  <= '0;
            drem_q  <= '0;
            state_q <= ST_DIV;
          end else begin
            iter_q <= iter_q + IterW'(1);
          end
        end
        ST_DIV: begin
          if (drem2 >= DremW'(cnt_q)) begin
            drem_q <= drem2 - DremW'(cnt_q);
            root_q <= {root_q[SqIter-2:0], 1'b1};
          end else begin
            drem_q <= drem2;
            root_q <= {root_q[SqIter-2:0], 1'b0};
          end
          if (iter_q == IterW'(SqIter - 1)) begin
            state_q <= ST_LOAD;
            if (op_q == OP_SDA) begin
              sda_q <= (drem2 >= DremW'(cnt_q)) ? {root_q[SdW-2:0], 1'b1}
                                                 : {root_q[SdW-2:0], 1'b0};
              op_q  <= OP_SDB;
            end else begin
              sdb_q <= (drem2 >= DremW'(cnt_q)) ? {root_q[SdW-2:0], 1'b1}
                                                 : {root_q[SdW-2:0], 1'b0};
              op_q  <= OP_XX;
            end
          end else begin
            iter_q <= iter_q + IterW'(1);
          end
        end
        ST_SCORE: begin
          score_q <= score_calc;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          valid_q <= 1'b1;
          cnt_q   <= '0;
          sa_q    <= '0;
          sb_q    <= '0;
          saa_q   <= '0;
          sbb_q   <= '0;
          sab_q   <= '0;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy    = (state_q != ST_IDLE);
  assign valid_o = valid_q;
  assign score_o = score_q;
  assign sd_a_o  = sda_q;
  assign sd_b_o  = sdb_q;

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy) else $error("result shown while busy");

  a_valid_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result strobe longer than one cycle");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> busy) else $error("last item did not start finishing");

  a_score_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (score_o <= (HalfRange << 1))) else $error("score out of range");

  a_acc_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (cnt_q == '0 && sa_q == '0 && sb_q == '0))
    else $error("accumulators not cleared after result");

endmodule

/* test/tb_normalized_ssd_patch_score.sv */
// Testbench for normalized_ssd_patch_score: streams pixel-pair patches and
// checks each score and deviation against an exact integer predictor.
// Depends on nssd_pkg and the normalized_ssd_patch_score RTL.
`timescale 1ns / 1ps

module tb_normalized_ssd_patch_score;
  import nssd_pkg::*;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic [SdW-1:0]    sd_a;
    logic [SdW-1:0]    sd_b;
  } patch_score_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [PixW-1:0]   pix_a_i = '0;
  logic [PixW-1:0]   pix_b_i = '0;
  logic              last_i = 1'b0;
  logic              valid_o;
  logic [ScoreW-1:0] score_o;
  logic [SdW-1:0]    sd_a_o;
  logic [SdW-1:0]    sd_b_o;

  patch_score_t expected_scores[$];
  longint unsigned pair_count, acc_a, acc_b, acc_ab, acc_aa, acc_bb;
  int mismatches = 0;
  int idle_pct = 0;
  int items_sent = 0;
  int stall_cycles = 0;

  always #5 clk_i = ~clk_i;

  normalized_ssd_patch_score DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .pix_a_i(pix_a_i), .pix_b_i(pix_b_i), .last_i(last_i),
    .valid_o(valid_o), .score_o(score_o), .sd_a_o(sd_a_o), .sd_b_o(sd_b_o)
  );

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= root + b) begin
        x -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // True when cv * 2^17 <= q * sqrt(va * vb).
  function automatic bit corr_at_most(longint cv, longint q, longint unsigned va,
                                      longint unsigned vb);
    logic [159:0] ac, aq, lhs, rhs;
    if (q >= 0 && cv <= 0) return 1'b1;
    if (q < 0 && cv >= 0) return 1'b0;
    ac = (cv < 0) ? -cv : cv;
    aq = (q < 0) ? -q : q;
    lhs = (ac * ac) << 34;
    rhs = aq * aq * 160'(va) * 160'(vb);
    return (q >= 0) ? (lhs <= rhs) : (lhs >= rhs);
  endfunction

  function automatic void clear_sums();
    pair_count = 0; acc_a = 0; acc_b = 0; acc_ab = 0; acc_aa = 0; acc_bb = 0;
  endfunction

  function automatic void predict_pair(logic [7:0] a, logic [7:0] b, logic last);
    longint unsigned n, va, vb;
    longint cv, lo, hi, mid;
    patch_score_t res;
    if (pair_count < MaxPixels) begin
      pair_count++;
      acc_a += a; acc_b += b;
      acc_ab += a * b; acc_aa += a * a; acc_bb += b * b;
    end
    if (!last) return;
    n = pair_count;
    va = n * acc_aa - acc_a * acc_a;
    vb = n * acc_bb - acc_b * acc_b;
    cv = longint'(n * acc_ab) - longint'(acc_a * acc_b);
    res.sd_a = SdW'(int_sqrt(va << 16) / n);
    res.sd_b = SdW'(int_sqrt(vb << 16) / n);
    if (va == 0) res.score = (vb == 0) ? '0 : ScoreOne;
    else if (vb == 0) res.score = ScoreOne;
    else begin
      lo = -131072;
      hi = 131072;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (corr_at_most(cv, mid, va, vb)) hi = mid;
        else lo = mid + 1;
      end
      res.score = ScoreW'(131072 - lo);
    end
    expected_scores.push_back(res);
    clear_sums();
  endfunction

  always @(posedge clk_i) begin
    patch_score_t want;
    if (rst_ni && valid_o) begin
      if (expected_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result score=%0d", score_o);
      end else begin
        want = expected_scores.pop_front();
        if (want.score !== score_o || want.sd_a !== sd_a_o || want.sd_b !== sd_b_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp score=%0d sd_a=%0d sd_b=%0d got %0d %0d %0d",
                     want.score, want.sd_a, want.sd_b, score_o, sd_a_o, sd_b_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > 50000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_pair(logic [7:0] a, logic [7:0] b, logic last);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    start <= 1'b1;
    pix_a_i <= a;
    pix_b_i <= b;
    last_i <= last;
    do @(posedge clk_i); while (busy);
    predict_pair(a, b, last);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic test_corner_patches();
    send_pair(8'd0, 8'd255, 1'b1);
    send_pair(8'd0, 8'd7, 1'b0); send_pair(8'd255, 8'd7, 1'b1);
    send_pair(8'd9, 8'd0, 1'b0); send_pair(8'd9, 8'd255, 1'b1);
    send_pair(8'd5, 8'd5, 1'b0); send_pair(8'd5, 8'd5, 1'b1);
    send_pair(8'd0, 8'd0, 1'b0); send_pair(8'd255, 8'd255, 1'b0);
    send_pair(8'd128, 8'd128, 1'b1);
    send_pair(8'd0, 8'd255, 1'b0); send_pair(8'd255, 8'd0, 1'b0);
    send_pair(8'd170, 8'd85, 1'b1);
    send_pair(8'd1, 8'd2, 1'b0); send_pair(8'd3, 8'd1, 1'b0);
    send_pair(8'd200, 8'd254, 1'b0); send_pair(8'd85, 8'd170, 1'b1);
    drain();
  endtask

  task automatic test_random_patches(int pairs, int pct);
    int len, kind, stop;
    logic [7:0] a, b;
    idle_pct = pct;
    stop = items_sent + pairs;
    while (items_sent < stop) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(200, 30) : $urandom_range(24, 1);
      kind = $urandom_range(5);
      for (int i = 0; i < len; i++) begin
        a = 8'($urandom);
        case (kind)
          0: b = a;
          1: b = 8'd255 - a;
          2: b = 8'(a / 2 + $urandom_range(9));
          3: b = 8'd77;
          default: b = 8'($urandom);
        endcase
        send_pair(a, b, i == len - 1);
      end
    end
    drain();
  endtask

  initial begin
    clear_sums();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_patches();
    test_random_patches(250, 0);
    test_random_patches(200, 50);
    test_random_patches(200, 16);
    test_random_patches(200, 0);
    if (mismatches == 0 && expected_scores.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* normalized_ssd_patch_score.f */
hw/rtl/nssd_pkg.sv
hw/rtl/normalized_ssd_patch_score.sv
test/tb_normalized_ssd_patch_score.sv
